// ===== hdl/thfp_pkg.sv =====
// Shared constants, types and codes for the tree height engine.
package thfp_pkg;

  // Node store sizing
  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int PAR_W     = 11;
  localparam int HGT_W     = 11;
  localparam int CMP_W     = ((CNT_W > PAR_W) ? CNT_W : PAR_W) + 1;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_LOOP  = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_OVF   = 2'd3
  } err_t;

  // Controller states
  typedef enum logic [1:0] {
    S_LOAD,
    S_EVAL,
    S_WALK,
    S_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ovf;
    logic bad_range;
    logic loop_hit;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/thfp_ctrl.sv =====
// Controller state machine for the tree height engine.
module thfp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_node,
  output logic          in_ready,
  input  thfp_pkg::sts_t sts,
  output thfp_pkg::cmd_t cmd
);
  import thfp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid && in_last_node) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.ovf || sts.bad_range) state_nxt = S_EMIT;
        else                          state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.loop_hit || sts.walk_end) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        cmd.start = !(sts.ovf || sts.bad_range);
      end
      S_WALK: begin
        cmd.step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/thfp_dp.sv =====
// Datapath: parent store, load checks, walk counters and result register.
module thfp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  thfp_pkg::cmd_t               cmd,
  output thfp_pkg::sts_t               sts,
  input  logic [thfp_pkg::PAR_W-1:0]   in_parent_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [thfp_pkg::HGT_W-1:0]   out_tree_height,
  output logic [1:0]                   out_error_code
);
  import thfp_pkg::*;

  // Parent store
  logic [PAR_W-1:0] mem [MAX_NODES];
  logic [PAR_W-1:0] q_r;

  // Load-side state
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             bad_neg_r;
  logic             has_par_r;
  logic [PAR_W-1:0] max_par_r;

  // Walk state
  logic [IDX_W-1:0] v_r;
  logic             first_r;
  logic [CNT_W-1:0] steps_r;
  logic [CNT_W-1:0] best_r;
  logic             loop_r;

  // Result register
  logic             out_valid_r;
  logic [HGT_W-1:0] height_r;
  err_t             code_r;

  logic             room;
  logic             is_neg;
  logic             is_root;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] steps_inc;
  logic [CNT_W-1:0] v_inc;
  logic             bad_range;
  err_t             code_sel;

  assign room      = count_r < CNT_W'(MAX_NODES);
  assign is_neg    = in_parent_index[PAR_W-1];
  assign is_root   = !first_r && (q_r == '1);
  assign rd_addr   = first_r ? v_r : IDX_W'(q_r);
  assign steps_inc = steps_r + CNT_W'(1);
  assign v_inc     = CNT_W'(v_r) + CNT_W'(1);
  assign bad_range = bad_neg_r || (has_par_r && (CMP_W'(max_par_r) >= CMP_W'(count_r)));

  // Status to controller
  always_comb begin
    sts.ovf       = ovf_r;
    sts.bad_range = bad_range;
    sts.loop_hit  = !is_root && (steps_inc > count_r);
    sts.walk_end  = is_root && (v_inc == count_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Store write on load while room remains, read on each walk step not at a root
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[count_r[IDX_W-1:0]] <= in_parent_index;
    end
    if (cmd.step && !is_root) begin
      q_r <= mem[rd_addr];
    end
  end

  // Node count and parent checks gathered while loading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      bad_neg_r <= 1'b0;
      has_par_r <= 1'b0;
    end else if (cmd.emit) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      bad_neg_r <= 1'b0;
      has_par_r <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count_r <= count_r + CNT_W'(1);
        if (is_neg && (in_parent_index != '1)) bad_neg_r <= 1'b1;
        if (!is_neg) has_par_r <= 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Largest non-negative parent seen
  always_ff @(posedge clk) begin
    if (cmd.load && room && !is_neg &&
        (!has_par_r || (in_parent_index > max_par_r))) begin
      max_par_r <= in_parent_index;
    end
  end

  // Walk: one parent hop per cycle, restart at next node on reaching a root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      loop_r  <= 1'b0;
    end else if (cmd.start) begin
      first_r <= 1'b1;
      loop_r  <= 1'b0;
    end else if (cmd.step) begin
      if (is_root) begin
        first_r <= 1'b1;
      end else begin
        first_r <= 1'b0;
        if (steps_inc > count_r) loop_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v_r     <= '0;
      steps_r <= '0;
      best_r  <= '0;
    end else if (cmd.step) begin
      if (is_root) begin
        if (steps_r > best_r) best_r <= steps_r;
        steps_r <= '0;
        v_r     <= v_r + IDX_W'(1);
      end else begin
        steps_r <= steps_inc;
      end
    end
  end

  // Error priority: overflow, bad parent, loop
  always_comb begin
    if (ovf_r)          code_sel = ERR_OVF;
    else if (bad_range) code_sel = ERR_RANGE;
    else if (loop_r)    code_sel = ERR_LOOP;
    else                code_sel = ERR_OK;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      code_r   <= code_sel;
      height_r <= (code_sel == ERR_OK) ? HGT_W'(best_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tree_height = height_r;
  assign out_error_code  = code_r;

  // A failed tree reports zero height
  a_err_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (code_r != ERR_OK) |-> height_r == '0)
    else $error("nonzero height with error code");

  // Node count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NODES))
    else $error("node count beyond store depth");

  // A loop is only flagged once the hop count has reached the node count
  a_loop_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.loop_hit |-> steps_r == count_r)
    else $error("loop flagged early");

  // A walk never runs on an empty tree
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> count_r != '0)
    else $error("walk on empty tree");

endmodule

// ===== hdl/tree_height_from_parents_core.sv =====
// Top level of the tree height engine: controller plus datapath.
//
//   channel | ports                                   | role
//   --------+-----------------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_parent_index,    | one node per item, node order
//           | in_last_node                            |
//   out     | out_valid, out_ready, out_tree_height,  | one result per tree
//           | out_error_code                          |
//
// Loading accepts node items back to back, writing each into the parent store. After the
// last node a check state (S_EVAL) runs, then the walk does one parent hop per cycle
// (one store read port).
// Reset clears counts and flags; the parent store needs no clearing.
// A result waiting on out_ready does not block loading of the next tree.
module tree_height_from_parents_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [thfp_pkg::PAR_W-1:0]   in_parent_index,
  input  logic                         in_last_node,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [thfp_pkg::HGT_W-1:0]   out_tree_height,
  output logic [1:0]                   out_error_code
);
  import thfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  thfp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Store, walk and result
  thfp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_parent_index (in_parent_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tree_height (out_tree_height),
    .out_error_code  (out_error_code)
  );

endmodule
